[rtl/lbc_pkg.sv]
package lbc_pkg;

    localparam int SIZE_BITS    = 25;
    localparam int OUT_KEY_BITS = 32;
    localparam int DATA_BITS    = 32;
    localparam int ADDR_BITS    = 3;

    localparam logic [SIZE_BITS-1:0] CAP_RESET    = 25'd1048576;
    localparam logic [SIZE_BITS-1:0] MAXOBJ_RESET = 25'd102400;

    // register indexes, taken from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_MAX_OBJ  = 1'b1;

    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_INSERT = 1'b1;

    typedef enum logic [2:0] {
        KIND_HIT      = 3'd0,
        KIND_MISS     = 3'd1,
        KIND_EVICTED  = 3'd2,
        KIND_INSERTED = 3'd3,
        KIND_REJECTED = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        CMP_KEY,
        CMP_LRU,
        CMP_UPD
    } t_cmp_mode;

endpackage

[rtl/lbc_req_if.sv]
interface lbc_req_if #(
    parameter int KEY_BITS = 32
);
    import lbc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 action;
    logic [KEY_BITS-1:0]  lookup_key;
    logic [SIZE_BITS-1:0] object_size;

    modport source (output valid, output action, output lookup_key, output object_size,
                    input ready);
    modport sink   (input valid, input action, input lookup_key, input object_size,
                    output ready);
endinterface

[rtl/lbc_rsp_if.sv]
interface lbc_rsp_if #(
    parameter int SLOT_BITS = 4
);
    import lbc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [2:0]              kind;
    logic [SLOT_BITS-1:0]    slot;
    logic [SIZE_BITS-1:0]    entry_size;
    logic [OUT_KEY_BITS-1:0] entry_key;
    logic                    last;

    modport source (output valid, output kind, output slot, output entry_size,
                    output entry_key, output last, input ready);
    modport sink   (input valid, input kind, input slot, input entry_size,
                    input entry_key, input last, output ready);
endinterface

[rtl/lbc_ram.sv]
module lbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/lbc_cmp_unit.sv]
module lbc_cmp_unit
    import lbc_pkg::*;
#(
    parameter int KEY_BITS  = 32,
    parameter int RANK_BITS = 4
) (
    input  t_cmp_mode            i_mode,
    input  logic                 i_valid,
    input  logic                 i_is_target,
    input  logic [KEY_BITS-1:0]  i_key_rd,
    input  logic [KEY_BITS-1:0]  i_ref_key,
    input  logic [RANK_BITS-1:0] i_rank_rd,
    input  logic [RANK_BITS-1:0] i_thr,
    input  logic [RANK_BITS-1:0] i_lru_rank,
    output logic                 o_match,
    output logic [RANK_BITS-1:0] o_rank_next
);

    always_comb begin
        o_match     = 1'b0;
        o_rank_next = i_rank_rd;
        unique case (i_mode)
            CMP_KEY: o_match = i_valid && (i_key_rd == i_ref_key);
            CMP_LRU: o_match = i_valid && (i_rank_rd == i_lru_rank);
            CMP_UPD: begin
                // target goes to front, younger valid entries age by one
                o_match = 1'b1;
                if (i_is_target) begin
                    o_rank_next = '0;
                end else if (i_valid && (i_rank_rd < i_thr)) begin
                    o_rank_next = i_rank_rd + RANK_BITS'(1);
                end
            end
            default: o_match = 1'b0;
        endcase
    end

endmodule

[rtl/lru_byte_budget_cache_directory.sv]
// Flow: a lookup miss or rejected insert scans the keys, then reports; a hit also updates the ranks.
// Insert: key scan and budget check, an LRU scan and an eviction beat per eviction, the free slot
// search, the rank update, then the write and the report.
// The key, LRU and rank passes step through the directory RAMs one entry a cycle on their single read port.
// One item is in flight; ready rises again in the cycle after the last beat loads the output register.
// Reset (synchronous, active low) clears valid bits, byte total and sequencer at once.
module lru_byte_budget_cache_directory
    import lbc_pkg::*;
#(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    lbc_req_if.sink              i_req,
    lbc_rsp_if.source            o_rsp,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_HSCAN,
        S_CHECK,
        S_VSCAN,
        S_EVICT,
        S_FREE,
        S_UPD,
        S_INSW,
        S_FIN
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [SIZE_BITS-1:0] r_cap, n_cap;
    logic [SIZE_BITS-1:0] r_maxobj, n_maxobj;

    // captured request
    logic                 r_action, n_action;
    logic [KEY_BITS-1:0]  r_key, n_key;
    logic [SIZE_BITS-1:0] r_size, n_size;

    // directory state in flops
    logic [ENTRIES-1:0]   r_valid, n_valid;
    logic [CW-1:0]        r_count, n_count;
    logic [SIZE_BITS-1:0] r_used, n_used;

    // scan machinery: r_idx issues reads, r_pidx tags the data in the cycle after
    logic [CW-1:0]        r_idx, n_idx;
    logic                 r_pend, n_pend;
    logic [IW-1:0]        r_pidx, n_pidx;

    // working result
    t_kind                r_kind, n_kind;
    logic [IW-1:0]        r_slot, n_slot;
    logic [SIZE_BITS-1:0] r_ebytes, n_ebytes;
    logic [KEY_BITS-1:0]  r_ekey, n_ekey;
    logic [IW-1:0]        r_thr, n_thr;

    // output register
    logic                 r_ov, n_ov;
    t_kind                r_okind, n_okind;
    logic [IW-1:0]        r_oslot, n_oslot;
    logic [SIZE_BITS-1:0] r_osize, n_osize;
    logic [KEY_BITS-1:0]  r_okey, n_okey;
    logic                 r_olast, n_olast;

    // RAM hookup
    logic [KEY_BITS-1:0]  key_rd;
    logic [SIZE_BITS-1:0] bytes_rd;
    logic [IW-1:0]        rank_rd;
    logic                 ins_we;
    logic                 rank_we;
    logic [IW-1:0]        rank_wdata;
    logic [IW-1:0]        raddr;

    t_cmp_mode            cmp_mode;
    logic                 cmp_match;
    logic                 cfg_wr;
    logic                 issuing;
    logic                 scan_last;
    logic                 out_free;
    logic                 fits;
    logic                 oversize;
    logic [SIZE_BITS:0]   sum_used;

    assign raddr     = r_idx[IW-1:0];
    assign issuing   = (r_idx < CW'(ENTRIES));
    assign scan_last = r_pend && (r_pidx == IW'(ENTRIES - 1));
    assign out_free  = !r_ov || o_rsp.ready;
    assign sum_used  = {1'b0, r_used} + {1'b0, r_size};
    assign fits      = (sum_used <= {1'b0, r_cap}) && (r_count < CW'(ENTRIES));
    assign oversize  = (r_size > r_maxobj) || (r_size > r_cap);
    assign ins_we    = (r_state == S_INSW);
    assign rank_we   = (r_state == S_UPD) && r_pend;

    always_comb begin
        unique case (r_state)
            S_HSCAN: cmp_mode = CMP_KEY;
            S_VSCAN: cmp_mode = CMP_LRU;
            default: cmp_mode = CMP_UPD;
        endcase
    end

    lbc_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (ins_we),
        .i_waddr (r_slot),
        .i_wdata (r_key),
        .i_raddr (raddr),
        .o_rdata (key_rd)
    );

    lbc_ram #(.WIDTH(SIZE_BITS), .DEPTH(ENTRIES)) u_bytes_ram (
        .i_clk   (i_clk),
        .i_we    (ins_we),
        .i_waddr (r_slot),
        .i_wdata (r_size),
        .i_raddr (raddr),
        .o_rdata (bytes_rd)
    );

    lbc_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_rank_ram (
        .i_clk   (i_clk),
        .i_we    (rank_we),
        .i_waddr (r_pidx),
        .i_wdata (rank_wdata),
        .i_raddr (raddr),
        .o_rdata (rank_rd)
    );

    // one compare unit serves key search, LRU search and rank update
    lbc_cmp_unit #(.KEY_BITS(KEY_BITS), .RANK_BITS(IW)) u_cmp (
        .i_mode      (cmp_mode),
        .i_valid     (r_valid[r_pidx]),
        .i_is_target (r_pidx == r_slot),
        .i_key_rd    (key_rd),
        .i_ref_key   (r_key),
        .i_rank_rd   (rank_rd),
        .i_thr       (r_thr),
        .i_lru_rank  (IW'(r_count - CW'(1))),
        .o_match     (cmp_match),
        .o_rank_next (rank_wdata)
    );

    // APB: write on the access phase, pready tied high
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_OBJ) ? DATA_BITS'(r_maxobj) : DATA_BITS'(r_cap);

    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_cap    = r_cap;
        n_maxobj = r_maxobj;
        n_action = r_action;
        n_key    = r_key;
        n_size   = r_size;
        n_valid  = r_valid;
        n_count  = r_count;
        n_used   = r_used;
        n_idx    = r_idx;
        n_pend   = 1'b0;
        n_pidx   = r_pidx;
        n_kind   = r_kind;
        n_slot   = r_slot;
        n_ebytes = r_ebytes;
        n_ekey   = r_ekey;
        n_thr    = r_thr;
        n_ov     = r_ov && !o_rsp.ready;
        n_okind  = r_okind;
        n_oslot  = r_oslot;
        n_osize  = r_osize;
        n_okey   = r_okey;
        n_olast  = r_olast;

        if (cfg_wr) begin
            if (paddr[2] == REG_CAPACITY) begin
                n_cap = pwdata[SIZE_BITS-1:0];
            end else begin
                n_maxobj = pwdata[SIZE_BITS-1:0];
            end
        end

        // advance the read pipeline in the RAM scan states
        if ((r_state == S_HSCAN) || (r_state == S_VSCAN) || (r_state == S_UPD)) begin
            n_pend = issuing;
            n_pidx = raddr;
            if (issuing) begin
                n_idx = r_idx + CW'(1);
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_action = i_req.action;
                    n_key    = i_req.lookup_key;
                    n_size   = i_req.object_size;
                    n_idx    = '0;
                    n_state  = S_HSCAN;
                end
            end
            S_HSCAN: begin
                if (r_pend && cmp_match) begin
                    n_kind   = KIND_HIT;
                    n_slot   = r_pidx;
                    n_ebytes = bytes_rd;
                    n_ekey   = key_rd;
                    n_thr    = rank_rd;
                    n_idx    = '0;
                    n_pend   = 1'b0;
                    n_state  = S_UPD;
                end else if (scan_last) begin
                    n_slot = '0;
                    n_ekey = r_key;
                    if (r_action == ACT_LOOKUP) begin
                        n_kind   = KIND_MISS;
                        n_ebytes = '0;
                        n_state  = S_FIN;
                    end else if (oversize) begin
                        n_kind   = KIND_REJECTED;
                        n_ebytes = r_size;
                        n_state  = S_FIN;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                n_idx = '0;
                if (fits || (r_count == '0)) begin
                    n_state = S_FREE;
                end else begin
                    n_state = S_VSCAN;
                end
            end
            S_VSCAN: begin
                // the least recent entry holds rank count-1
                if (r_pend && cmp_match) begin
                    n_kind   = KIND_EVICTED;
                    n_slot   = r_pidx;
                    n_ebytes = bytes_rd;
                    n_ekey   = key_rd;
                    n_pend   = 1'b0;
                    n_state  = S_EVICT;
                end
            end
            S_EVICT: begin
                if (out_free) begin
                    n_ov            = 1'b1;
                    n_okind         = r_kind;
                    n_oslot         = r_slot;
                    n_osize         = r_ebytes;
                    n_okey          = r_ekey;
                    n_olast         = 1'b0;
                    n_valid[r_slot] = 1'b0;
                    n_count         = r_count - CW'(1);
                    n_used          = (r_used >= r_ebytes) ? (r_used - r_ebytes) : '0;
                    n_state         = S_CHECK;
                end
            end
            S_FREE: begin
                // walk valid bits to the lowest free slot
                if (!r_valid[raddr]) begin
                    n_kind   = KIND_INSERTED;
                    n_slot   = raddr;
                    n_ebytes = r_size;
                    n_ekey   = r_key;
                    n_thr    = IW'(r_count);
                    n_idx    = '0;
                    n_state  = S_UPD;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            S_UPD: begin
                if (scan_last) begin
                    n_state = (r_kind == KIND_HIT) ? S_FIN : S_INSW;
                end
            end
            S_INSW: begin
                n_valid[r_slot] = 1'b1;
                n_count         = r_count + CW'(1);
                n_used          = sum_used[SIZE_BITS-1:0];
                n_state         = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_okind = r_kind;
                    n_oslot = r_slot;
                    n_osize = r_ebytes;
                    n_okey  = r_ekey;
                    n_olast = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cap    <= CAP_RESET;
            r_maxobj <= MAXOBJ_RESET;
            r_valid  <= '0;
            r_count  <= '0;
            r_used   <= '0;
            r_idx    <= '0;
            r_pend   <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cap    <= n_cap;
            r_maxobj <= n_maxobj;
            r_valid  <= n_valid;
            r_count  <= n_count;
            r_used   <= n_used;
            r_idx    <= n_idx;
            r_pend   <= n_pend;
            r_ov     <= n_ov;
        end
        r_action <= n_action;
        r_key    <= n_key;
        r_size   <= n_size;
        r_pidx   <= n_pidx;
        r_kind   <= n_kind;
        r_slot   <= n_slot;
        r_ebytes <= n_ebytes;
        r_ekey   <= n_ekey;
        r_thr    <= n_thr;
        r_okind  <= n_okind;
        r_oslot  <= n_oslot;
        r_osize  <= n_osize;
        r_okey   <= n_okey;
        r_olast  <= n_olast;
    end

    assign o_rsp.valid      = r_ov;
    assign o_rsp.kind       = r_okind;
    assign o_rsp.slot       = r_oslot;
    assign o_rsp.entry_size = r_osize;
    assign o_rsp.last       = r_olast;

    // report the low key bits, zero-filled for narrow keys
    generate
        if (KEY_BITS >= OUT_KEY_BITS) begin : g_key_wide
            assign o_rsp.entry_key = r_okey[OUT_KEY_BITS-1:0];
        end else begin : g_key_narrow
            assign o_rsp.entry_key = {{(OUT_KEY_BITS-KEY_BITS){1'b0}}, r_okey};
        end
    endgenerate

endmodule

[bench/lru_byte_budget_cache_directory_test.sv]
module lru_byte_budget_cache_directory_test;
    import lbc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES         = 16;
    localparam int KEY_POOL        = 20;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int SETTLE_CYCLES   = 2 * ENTRIES + 8;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int REPORT_LIMIT    = 10;

    localparam logic [SIZE_BITS-1:0] SIZE_TOP = 25'd16777216;

    // One row of the directed table: either a request beat or a register write.
    typedef enum logic {
        ROW_ITEM,
        ROW_WRITE
    } row_kind_e;

    typedef struct packed {
        row_kind_e            kind;
        logic                 action;
        logic                 reg_sel;
        logic [31:0]          key;
        logic [SIZE_BITS-1:0] size;      // object size, or the value on a write row
        logic                 typed;     // expectation given in the row itself
        t_kind                exp_kind;
        logic [3:0]           exp_slot;
        logic [SIZE_BITS-1:0] exp_size;
    } dir_row_t;

    typedef struct packed {
        t_kind                   kind;
        logic [3:0]              slot;
        logic [SIZE_BITS-1:0]    size;
        logic [OUT_KEY_BITS-1:0] key;
        logic                    last;
    } dir_result_t;

    typedef struct packed {
        logic [SIZE_BITS-1:0] budget;
        logic [SIZE_BITS-1:0] max_obj;
        logic [SIZE_BITS-1:0] size_hi;
        logic                 quiet;     // no idling on either side
    } phase_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0] pwdata;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    lbc_req_if #(.KEY_BITS(32)) req_bus ();
    lbc_rsp_if #(.SLOT_BITS(4)) rsp_bus ();

    lru_byte_budget_cache_directory #(
        .ENTRIES (ENTRIES),
        .KEY_BITS(32)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_bus),
        .o_rsp  (rsp_bus),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    // Directed table. Rows with typed set carry their own expectation (single result);
    // all other rows are checked against the directory predictor.
    dir_row_t directed_rows [28] = '{
        // reset budget 1 MiB, largest object 100 KiB
        '{ROW_ITEM,  ACT_LOOKUP, REG_CAPACITY, 32'h0000_0000, 25'd0,      1'b1, KIND_MISS,     4'd0, 25'd0},
        '{ROW_ITEM,  ACT_INSERT, REG_CAPACITY, 32'h0000_0000, 25'd0,      1'b1, KIND_INSERTED, 4'd0, 25'd0},
        '{ROW_ITEM,  ACT_INSERT, REG_CAPACITY, 32'hFFFF_FFFF, 25'd102400, 1'b1, KIND_INSERTED, 4'd1, 25'd102400},
        '{ROW_ITEM,  ACT_INSERT, REG_CAPACITY, 32'h1234_5678, 25'd102401, 1'b1, KIND_REJECTED, 4'd0, 25'd102401},
        '{ROW_ITEM,  ACT_LOOKUP, REG_CAPACITY, 32'hFFFF_FFFF, SIZE_TOP,   1'b1, KIND_HIT,      4'd1, 25'd102400},
        '{ROW_ITEM,  ACT_INSERT, REG_CAPACITY, 32'h0000_0000, 25'd500,    1'b1, KIND_HIT,      4'd0, 25'd0},
        '{ROW_ITEM,  ACT_INSERT, REG_CAPACITY, 32'h1000_0001, 25'd100000, 1'b0, KIND_HIT,      4'd0, 25'd0},
        '{ROW_ITEM,  ACT_INSERT, REG_CAPACITY, 32'h1000_0002, 25'd100000, 1'b0, KIND_HIT,      4'd0, 25'd0},
        '{ROW_ITEM,  ACT_INSERT, REG_CAPACITY, 32'h1000_0003, 25'd100000, 1'b0, KIND_HIT,      4'd0, 25'd0},
        '{ROW_ITEM,  ACT_INSERT, REG_CAPACITY, 32'h1000_0004, 25'd100000, 1'b0, KIND_HIT,      4'd0, 25'd0},
        '{ROW_ITEM,  ACT_INSERT, REG_CAPACITY, 32'h1000_0005, 25'd100000, 1'b0, KIND_HIT,      4'd0, 25'd0},
        '{ROW_ITEM,  ACT_INSERT, REG_CAPACITY, 32'h1000_0006, 25'd100000, 1'b0, KIND_HIT,      4'd0, 25'd0},
        '{ROW_ITEM,  ACT_INSERT, REG_CAPACITY, 32'h1000_0007, 25'd100000, 1'b0, KIND_HIT,      4'd0, 25'd0},
        '{ROW_ITEM,  ACT_INSERT, REG_CAPACITY, 32'h1000_0008, 25'd100000, 1'b0, KIND_HIT,      4'd0, 25'd0},
        '{ROW_ITEM,  ACT_INSERT, REG_CAPACITY, 32'h1000_0009, 25'd100000, 1'b0, KIND_HIT,      4'd0, 25'd0},
        // budget overflow: evict the least recent entry first
        '{ROW_ITEM,  ACT_INSERT, REG_CAPACITY, 32'h2000_0000, 25'd100000, 1'b0, KIND_HIT,      4'd0, 25'd0},
        // lower the budget, then insert: evict down to the new budget
        '{ROW_WRITE, ACT_LOOKUP, REG_MAX_OBJ,  32'h0000_0000, SIZE_TOP,   1'b0, KIND_HIT,      4'd0, 25'd0},
        '{ROW_WRITE, ACT_LOOKUP, REG_CAPACITY, 32'h0000_0000, 25'd300000, 1'b0, KIND_HIT,      4'd0, 25'd0},
        '{ROW_ITEM,  ACT_INSERT, REG_CAPACITY, 32'h3000_0000, 25'd50000,  1'b0, KIND_HIT,      4'd0, 25'd0},
        // above the budget but within the object limit
        '{ROW_ITEM,  ACT_INSERT, REG_CAPACITY, 32'h3000_0001, 25'd300001, 1'b1, KIND_REJECTED, 4'd0, 25'd300001},
        // largest budget and largest object: evict everything
        '{ROW_WRITE, ACT_LOOKUP, REG_CAPACITY, 32'h0000_0000, SIZE_TOP,   1'b0, KIND_HIT,      4'd0, 25'd0},
        '{ROW_ITEM,  ACT_INSERT, REG_CAPACITY, 32'h4000_0000, SIZE_TOP,   1'b0, KIND_HIT,      4'd0, 25'd0},
        '{ROW_ITEM,  ACT_LOOKUP, REG_CAPACITY, 32'h4000_0000, 25'd7,      1'b0, KIND_HIT,      4'd0, 25'd0},
        // smallest settings: only empty objects fit
        '{ROW_WRITE, ACT_LOOKUP, REG_CAPACITY, 32'h0000_0000, 25'd1,      1'b0, KIND_HIT,      4'd0, 25'd0},
        '{ROW_WRITE, ACT_LOOKUP, REG_MAX_OBJ,  32'h0000_0000, 25'd0,      1'b0, KIND_HIT,      4'd0, 25'd0},
        '{ROW_ITEM,  ACT_INSERT, REG_CAPACITY, 32'h0000_5000, 25'd1,      1'b1, KIND_REJECTED, 4'd0, 25'd1},
        '{ROW_ITEM,  ACT_INSERT, REG_CAPACITY, 32'h0000_5000, 25'd0,      1'b0, KIND_HIT,      4'd0, 25'd0},
        '{ROW_ITEM,  ACT_LOOKUP, REG_CAPACITY, 32'h4000_0000, 25'd0,      1'b1, KIND_MISS,     4'd0, 25'd0}
    };

    // Random phases: budget, object limit, largest size drawn, and whether idling is off.
    phase_t random_phases [5] = '{
        '{25'd1048576, 25'd102400,  25'd110000, 1'b0},
        '{25'd4096,    25'd1024,    25'd1300,   1'b1},
        '{25'd1,       25'd0,       25'd1,      1'b0},
        '{SIZE_TOP,    SIZE_TOP,    SIZE_TOP,   1'b0},
        '{25'd200000,  25'd150000,  25'd160000, 1'b0}
    };

    // Predictor state: a private copy of the directory and of both registers.
    logic                 dir_valid [ENTRIES];
    logic [31:0]          dir_key   [ENTRIES];
    logic [SIZE_BITS-1:0] dir_bytes [ENTRIES];
    logic [3:0]           dir_rank  [ENTRIES];
    logic [SIZE_BITS-1:0] used_bytes;
    logic [SIZE_BITS-1:0] budget_bytes;
    logic [SIZE_BITS-1:0] max_obj_bytes;

    dir_result_t step_results [$];       // results of the request just accepted
    dir_result_t expected_results [$];   // in flight, oldest first

    int unsigned idle_pct = 27;
    int unsigned failure_count = 0;
    int unsigned cycle_count = 0;

    // 83.3 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // Timeout: a stuck handshake or a lost result ends here.
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic void flag_failure(string msg);
        failure_count++;
        if (failure_count <= REPORT_LIMIT) $display("%s", msg);
    endfunction

    function automatic int first_free_slot();
        for (int i = 0; i < ENTRIES; i++) begin
            if (!dir_valid[i]) return i;
        end
        return -1;
    endfunction

    // Work out the results of one request and advance the directory copy.
    function automatic void predict_directory(logic action, logic [31:0] key,
                                              logic [SIZE_BITS-1:0] size);
        int         hit_slot;
        int         victim;
        int         free_slot;
        logic [3:0] old_rank;
        step_results.delete();
        hit_slot = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (hit_slot < 0 && dir_valid[i] && dir_key[i] == key) hit_slot = i;
        end
        // Resident key, lookup or insert alike: promote to most recent, keep stored size.
        if (hit_slot >= 0) begin
            old_rank = dir_rank[hit_slot];
            for (int i = 0; i < ENTRIES; i++) begin
                if (dir_valid[i] && dir_rank[i] < old_rank) dir_rank[i]++;
            end
            dir_rank[hit_slot] = '0;
            step_results.push_back('{KIND_HIT, 4'(hit_slot), dir_bytes[hit_slot],
                                     dir_key[hit_slot], 1'b1});
            return;
        end
        if (action == ACT_LOOKUP) begin
            step_results.push_back('{KIND_MISS, 4'd0, '0, key, 1'b1});
            return;
        end
        if (size > max_obj_bytes || size > budget_bytes) begin
            step_results.push_back('{KIND_REJECTED, 4'd0, size, key, 1'b1});
            return;
        end
        // Evict least recent entries until the object fits and a slot is free.
        for (int n = 0; n < ENTRIES; n++) begin
            if (int'(used_bytes) + int'(size) <= int'(budget_bytes) && first_free_slot() >= 0)
                break;
            victim = -1;
            for (int i = 0; i < ENTRIES; i++) begin
                if (dir_valid[i] && (victim < 0 || dir_rank[i] > dir_rank[victim])) victim = i;
            end
            if (victim < 0) break;
            dir_valid[victim] = 1'b0;
            used_bytes = (used_bytes >= dir_bytes[victim]) ? used_bytes - dir_bytes[victim] : '0;
            step_results.push_back('{KIND_EVICTED, 4'(victim), dir_bytes[victim],
                                     dir_key[victim], 1'b0});
        end
        free_slot = first_free_slot();
        if (free_slot < 0) begin
            step_results.push_back('{KIND_REJECTED, 4'd0, size, key, 1'b1});
            return;
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (dir_valid[i]) dir_rank[i]++;
        end
        dir_valid[free_slot] = 1'b1;
        dir_key[free_slot]   = key;
        dir_bytes[free_slot] = size;
        dir_rank[free_slot]  = '0;
        used_bytes           = used_bytes + size;
        step_results.push_back('{KIND_INSERTED, 4'(free_slot), size, key, 1'b1});
    endfunction

    // Offer one request beat, idling at random first; leave valid high on return.
    // On acceptance queue either the row's own expectation or the predicted results.
    task automatic send_request(logic action, logic [31:0] key, logic [SIZE_BITS-1:0] size,
                                logic typed, t_kind exp_kind, logic [3:0] exp_slot,
                                logic [SIZE_BITS-1:0] exp_size);
        while ($urandom_range(0, 99) < idle_pct) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.action      <= action;
        req_bus.lookup_key  <= key;
        req_bus.object_size <= size;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        predict_directory(action, key, size);
        if (typed) begin
            expected_results.push_back('{exp_kind, exp_slot, exp_size, key, 1'b1});
        end else begin
            foreach (step_results[i]) expected_results.push_back(step_results[i]);
        end
    endtask

    // Drop valid and hold until every expected beat is back, then let the block settle.
    task automatic drain_results();
        req_bus.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write: setup phase, access phase until pready, then back to idle.
    task automatic write_register(logic reg_sel, logic [SIZE_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS'({reg_sel, 2'b00});
        pwdata  <= DATA_BITS'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_CAPACITY) budget_bytes = value;
        else max_obj_bytes = value;
        @(posedge i_clk);
    endtask

    // Result side: check each accepted beat against the oldest expectation,
    // then draw ready for the next cycle.
    initial begin
        dir_result_t got;
        dir_result_t want;
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
                got = '{t_kind'(rsp_bus.kind), rsp_bus.slot, rsp_bus.entry_size,
                        rsp_bus.entry_key, rsp_bus.last};
                if (expected_results.size() == 0) begin
                    flag_failure($sformatf(
                        "unexpected result: kind=%0d slot=%0d size=%0d key=%h last=%b",
                        got.kind, got.slot, got.size, got.key, got.last));
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        flag_failure($sformatf({"result mismatch: expected kind=%0d slot=%0d ",
                            "size=%0d key=%h last=%b, got kind=%0d slot=%0d size=%0d key=%h ",
                            "last=%b"}, want.kind, want.slot, want.size, want.key, want.last,
                            got.kind, got.slot, got.size, got.key, got.last));
                    end
                end
            end
            rsp_bus.ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    // Stimulus: reset, directed table, then random phases under varied settings.
    initial begin
        logic [31:0]          key_pool [KEY_POOL];
        logic                 action;
        logic [31:0]          key;
        logic [SIZE_BITS-1:0] size;
        int unsigned          roll;

        // Drive every input to a known value before the first edge.
        i_rst_n             <= 1'b0;
        req_bus.valid       <= 1'b0;
        req_bus.action      <= ACT_LOOKUP;
        req_bus.lookup_key  <= '0;
        req_bus.object_size <= '0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;

        // Predictor reset mirrors the block's reset.
        for (int i = 0; i < ENTRIES; i++) begin
            dir_valid[i] = 1'b0;
            dir_key[i]   = '0;
            dir_bytes[i] = '0;
            dir_rank[i]  = '0;
        end
        used_bytes    = '0;
        budget_bytes  = CAP_RESET;
        max_obj_bytes = MAXOBJ_RESET;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table; register writes only once the block is idle.
        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_WRITE) begin
                drain_results();
                write_register(directed_rows[r].reg_sel, directed_rows[r].size);
            end else begin
                send_request(directed_rows[r].action, directed_rows[r].key,
                             directed_rows[r].size, directed_rows[r].typed,
                             directed_rows[r].exp_kind, directed_rows[r].exp_slot,
                             directed_rows[r].exp_size);
            end
        end

        foreach (random_phases[p]) begin
            drain_results();
            write_register(REG_CAPACITY, random_phases[p].budget);
            write_register(REG_MAX_OBJ, random_phases[p].max_obj);
            idle_pct = random_phases[p].quiet ? 0 : 27;
            // A pool a little larger than the directory keeps hits and evictions frequent.
            foreach (key_pool[k]) key_pool[k] = $urandom();
            repeat (ITEMS_PER_PHASE) begin
                action = ($urandom_range(0, 99) < 55) ? ACT_INSERT : ACT_LOOKUP;
                key    = ($urandom_range(0, 9) == 0) ? $urandom()
                                                     : key_pool[$urandom_range(0, KEY_POOL - 1)];
                roll   = $urandom_range(0, 99);
                // Bias sizes toward the object limit and just past it.
                if (roll < 5)
                    size = max_obj_bytes;
                else if (roll < 10)
                    size = (max_obj_bytes < SIZE_TOP) ? max_obj_bytes + 1'b1 : max_obj_bytes;
                else if (random_phases[p].size_hi == SIZE_TOP && roll < 80)
                    size = SIZE_BITS'($urandom_range(0, 300000));
                else
                    size = SIZE_BITS'($urandom_range(0, random_phases[p].size_hi));
                send_request(action, key, size, 1'b0, KIND_HIT, 4'd0, '0);
                // Now and then hold the sender until the directory has caught up.
                if ($urandom_range(0, 29) == 0) drain_results();
            end
            idle_pct = 27;
        end

        drain_results();
        if (failure_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
